/* rtl/mmbd_pkg.sv */
`default_nettype none

package mmbd_pkg;

    // Map sizes
    localparam int LOW_RAM_DEPTH  = 40960;
    localparam int FREE_RAM_DEPTH = 4096;
    localparam int CIA_REG_COUNT  = 16;
    localparam int LOW_AW         = $clog2(LOW_RAM_DEPTH);
    localparam int FREE_AW        = $clog2(FREE_RAM_DEPTH);
    localparam int CIA_AW         = $clog2(CIA_REG_COUNT);
    localparam int BOOT_LEN       = 14;

    // Region boundaries
    localparam logic [15:0] BASIC_BASE  = 16'hA000;
    localparam logic [15:0] FREE_BASE   = 16'hC000;
    localparam logic [15:0] VIDEO_BASE  = 16'hD000;
    localparam logic [15:0] SOUND_BASE  = 16'hD400;
    localparam logic [15:0] CIA1_BASE   = 16'hDC00;
    localparam logic [15:0] CIA2_BASE   = 16'hDD00;
    localparam logic [15:0] EXP_BASE    = 16'hDE00;
    localparam logic [15:0] KERNAL_BASE = 16'hE000;
    localparam logic [15:0] SCREEN_BASE = 16'h0400;
    localparam logic [15:0] SCREEN_END  = 16'h0800;
    localparam logic [15:0] ZOOM_ADDR   = 16'hCFF1;
    localparam logic [15:0] COLOR_ADDR  = 16'hCFF2;
    localparam logic [7:0]  COLOR_PAIRS = 8'd6;

    // Target codes
    localparam logic [2:0] TGT_NONE   = 3'd0;
    localparam logic [2:0] TGT_VIDEO  = 3'd1;
    localparam logic [2:0] TGT_SCREEN = 3'd2;
    localparam logic [2:0] TGT_CIA1   = 3'd3;
    localparam logic [2:0] TGT_BASIC  = 3'd4;
    localparam logic [2:0] TGT_KERNAL = 3'd5;

    localparam logic MODE_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    function automatic logic [15:0] rgb565(input logic [4:0] r, input logic [5:0] g,
                                           input logic [4:0] b);
        return {r, g, b};
    endfunction

    function automatic logic [15:0] bright_of(input logic [2:0] sel);
        logic [15:0] c;
        case (sel)
            3'd0:    c = rgb565(5'd25, 6'd56, 5'd31);
            3'd1:    c = rgb565(5'd11, 6'd35, 5'd8);
            3'd2:    c = rgb565(5'd1,  6'd10, 5'd4);
            3'd3:    c = rgb565(5'd31, 6'd63, 5'd31);
            3'd4:    c = rgb565(5'd0,  6'd0,  5'd0);
            3'd5:    c = rgb565(5'd10, 6'd48, 5'd31);
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [15:0] dark_of(input logic [2:0] sel);
        logic [15:0] c;
        case (sel)
            3'd0:    c = rgb565(5'd5,  6'd8,  5'd26);
            3'd1:    c = rgb565(5'd1,  6'd10, 5'd4);
            3'd2:    c = rgb565(5'd11, 6'd35, 5'd8);
            3'd3:    c = rgb565(5'd0,  6'd0,  5'd0);
            3'd4:    c = rgb565(5'd31, 6'd63, 5'd31);
            3'd5:    c = rgb565(5'd4,  6'd8,  5'd4);
            default: c = '0;
        endcase
        return c;
    endfunction

    // Boot image at the bottom of free RAM
    function automatic logic [7:0] boot_byte(input logic [FREE_AW-1:0] idx);
        logic [7:0] b;
        case (idx)
            12'd0:   b = 8'd120;
            12'd1:   b = 8'd162;
            12'd2:   b = 8'd0;
            12'd3:   b = 8'd160;
            12'd4:   b = 8'd0;
            12'd5:   b = 8'd200;
            12'd6:   b = 8'd208;
            12'd7:   b = 8'd253;
            12'd8:   b = 8'd232;
            12'd9:   b = 8'd208;
            12'd10:  b = 8'd250;
            12'd11:  b = 8'd108;
            12'd12:  b = 8'd252;
            12'd13:  b = 8'd255;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* rtl/mmbd_ram.sv */
`default_nettype none

module mmbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/memory_map_bus_decoder_top.sv */
// Channel   Signals                                   Direction  Handshake
// -------   ---------------------------------------   ---------  -------------------------
// request   mode, addr, wdata, ext_data               in         start high, busy low
// result    rdata, target, dev_offset, dev_wdata,     out        done high for one cycle
//           zoom, bright_color, dark_color
//
// After reset the block sweeps all 40960 low RAM entries (busy high): low RAM is
// zeroed and free RAM is loaded with the boot image and zeros, one entry per cycle.
// Afterwards busy stays low and one request is taken every cycle. RAM writes, CIA2
// register writes and zoom/colour updates land on the accepting edge; reads go
// through the registered RAM port into the request stage, and done and the result
// are registered in the result stage after it. The single RAM port per region sets
// the one-request-per-cycle rate.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module memory_map_bus_decoder_top
    import mmbd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        mode,
    input  wire logic [15:0] addr,
    input  wire logic [7:0]  wdata,
    input  wire logic [7:0]  ext_data,
    output logic             done,
    output logic [7:0]       rdata,
    output logic [2:0]       target,
    output logic [12:0]      dev_offset,
    output logic [7:0]       dev_wdata,
    output logic [7:0]       zoom,
    output logic [15:0]      bright_color,
    output logic [15:0]      dark_color
);

    state_t             state_reg, state_next;
    logic [LOW_AW-1:0]  clr_reg, clr_next;

    logic               acc;
    logic               clearing;

    // request stage
    logic               req_valid_reg;
    logic               req_mode_reg;
    logic [15:0]        req_addr_reg;
    logic [7:0]         req_wdata_reg;
    logic [7:0]         req_ext_reg;

    // programmable display state
    logic [7:0]         zoom_reg;
    logic [15:0]        bright_reg;
    logic [15:0]        dark_reg;
    logic [7:0]         cia_reg [CIA_REG_COUNT];

    // result stage
    logic               done_reg;
    logic [7:0]         rdata_reg, rdata_next;
    logic [2:0]         target_reg, target_next;
    logic [12:0]        off_reg, off_next;
    logic [7:0]         dwd_reg, dwd_next;
    logic [7:0]         zoom_out_reg;
    logic [15:0]        bright_out_reg;
    logic [15:0]        dark_out_reg;

    // RAM ports
    logic               low_en, low_we;
    logic [LOW_AW-1:0]  low_addr;
    logic [7:0]         low_wdata, low_rdata;
    logic               free_en, free_we;
    logic [FREE_AW-1:0] free_addr;
    logic [7:0]         free_wdata, free_rdata;

    logic               in_low, in_free, in_cia2;
    logic               clr_free;

    assign clearing = (state_reg == ST_CLEAR);
    assign busy     = clearing;
    assign acc      = start && !busy;

    // Region hits for the incoming request (write side acts on the accepting edge)
    assign in_low  = (addr < BASIC_BASE);
    assign in_free = (addr >= FREE_BASE) && (addr < VIDEO_BASE);
    assign in_cia2 = (addr >= CIA2_BASE) && (addr < EXP_BASE);

    // Clearing pass control
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LOW_AW'(LOW_RAM_DEPTH - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                clr_next = clr_reg;
            end
            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    // Free RAM only spans the lower part of the clearing sweep
    assign clr_free = (clr_reg < LOW_AW'(FREE_RAM_DEPTH));

    // Low RAM port: clearing sweep, else the bus request
    always_comb
    begin
        if (clearing)
        begin
            low_en    = 1'b1;
            low_we    = 1'b1;
            low_addr  = clr_reg;
            low_wdata = '0;
        end
        else
        begin
            low_en    = acc && in_low;
            low_we    = (mode == MODE_WRITE);
            low_addr  = addr[LOW_AW-1:0];
            low_wdata = wdata;
        end
    end

    // Free RAM port: boot image load, else the bus request
    always_comb
    begin
        if (clearing)
        begin
            free_en    = clr_free;
            free_we    = 1'b1;
            free_addr  = clr_reg[FREE_AW-1:0];
            free_wdata = boot_byte(clr_reg[FREE_AW-1:0]);
        end
        else
        begin
            free_en    = acc && in_free;
            free_we    = (mode == MODE_WRITE);
            free_addr  = addr[FREE_AW-1:0];
            free_wdata = wdata;
        end
    end

    mmbd_ram #(
        .WIDTH (8),
        .DEPTH (LOW_RAM_DEPTH)
    ) u_low_ram (
        .clk   (clk),
        .en    (low_en),
        .we    (low_we),
        .addr  (low_addr),
        .wdata (low_wdata),
        .rdata (low_rdata)
    );

    mmbd_ram #(
        .WIDTH (8),
        .DEPTH (FREE_RAM_DEPTH)
    ) u_free_ram (
        .clk   (clk),
        .en    (free_en),
        .we    (free_we),
        .addr  (free_addr),
        .wdata (free_wdata),
        .rdata (free_rdata)
    );

    // CIA2 registers, zoom and colour pair: written on the accepting edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_reg   <= '0;
            bright_reg <= '0;
            dark_reg   <= '0;
            for (int i = 0; i < CIA_REG_COUNT; i++)
            begin
                cia_reg[i] <= '0;
            end
        end
        else if (acc && (mode == MODE_WRITE))
        begin
            if (in_cia2)
            begin
                cia_reg[addr[CIA_AW-1:0]] <= wdata;
            end
            if (addr == ZOOM_ADDR)
            begin
                zoom_reg <= wdata;
            end
            // out-of-range select leaves the pair alone
            if ((addr == COLOR_ADDR) && (wdata < COLOR_PAIRS))
            begin
                bright_reg <= bright_of(wdata[2:0]);
                dark_reg   <= dark_of(wdata[2:0]);
            end
        end
    end

    // Request stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            req_mode_reg  <= mode;
            req_addr_reg  <= addr;
            req_wdata_reg <= wdata;
            req_ext_reg   <= ext_data;
        end
    end

    // Decode the staged request against the RAM read data
    always_comb
    begin
        logic wr;
        logic [15:0] a;
        wr          = (req_mode_reg == MODE_WRITE);
        a           = req_addr_reg;
        rdata_next  = '0;
        target_next = TGT_NONE;
        off_next    = '0;
        dwd_next    = '0;
        if (a < BASIC_BASE)
        begin
            if (wr)
            begin
                // screen writes also notify the video side
                if ((a >= SCREEN_BASE) && (a < SCREEN_END))
                begin
                    target_next = TGT_SCREEN;
                    off_next    = {3'b000, a[9:0]};
                    dwd_next    = req_wdata_reg;
                end
            end
            else
            begin
                rdata_next = low_rdata;
            end
        end
        else if (a < FREE_BASE)
        begin
            if (!wr)
            begin
                target_next = TGT_BASIC;
                off_next    = a[12:0];
                rdata_next  = req_ext_reg;
            end
        end
        else if (a < VIDEO_BASE)
        begin
            if (!wr)
            begin
                rdata_next = free_rdata;
            end
        end
        else if (a < SOUND_BASE)
        begin
            target_next = TGT_VIDEO;
            off_next    = {3'b000, a[9:0]};
            if (wr)
            begin
                dwd_next = req_wdata_reg;
            end
            else
            begin
                rdata_next = req_ext_reg;
            end
        end
        else if (a < CIA1_BASE)
        begin
            // sound and colour RAM: nothing
        end
        else if (a < CIA2_BASE)
        begin
            target_next = TGT_CIA1;
            off_next    = {9'b0, a[3:0]};
            if (wr)
            begin
                dwd_next = req_wdata_reg;
            end
            else
            begin
                rdata_next = req_ext_reg;
            end
        end
        else if (a < EXP_BASE)
        begin
            if (!wr)
            begin
                rdata_next = cia_reg[a[CIA_AW-1:0]];
            end
        end
        else if (a < KERNAL_BASE)
        begin
            // expansion: nothing
        end
        else
        begin
            if (!wr)
            begin
                target_next = TGT_KERNAL;
                off_next    = a[12:0];
                rdata_next  = req_ext_reg;
            end
        end
    end

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req_valid_reg;
        end
    end

    // zoom/colour sampled here already include the staged request's own update
    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            rdata_reg      <= rdata_next;
            target_reg     <= target_next;
            off_reg        <= off_next;
            dwd_reg        <= dwd_next;
            zoom_out_reg   <= zoom_reg;
            bright_out_reg <= bright_reg;
            dark_out_reg   <= dark_reg;
        end
    end

    assign done         = done_reg;
    assign rdata        = rdata_reg;
    assign target       = target_reg;
    assign dev_offset   = off_reg;
    assign dev_wdata    = dwd_reg;
    assign zoom         = zoom_out_reg;
    assign bright_color = bright_out_reg;
    assign dark_color   = dark_out_reg;

endmodule

`default_nettype wire
